// ===== rtl/tfn_pkg.sv =====
// tfn_pkg: shared constants for the triangle face normal core
// no dependencies
`timescale 1ns / 1ps
package tfn_pkg;
    localparam int MAG_WIDTH = 31;
    localparam int OUT_WIDTH = 16;
endpackage

// ===== rtl/triangle_face_normal_core.sv =====
// triangle_face_normal_core: unit face normal of one triangle per transaction
// accepts one transaction per cycle while m_tready does not stall the pipe
// the depth is set by the bit-serial compare chain, one result bit per pipeline stage
// each stage updates d^2*S and d*S by shift and add and holds a 128-bit compare
// reset: aresetn synchronous active low, clears the valid bits only
// depends on tfn_pkg
`timescale 1ns / 1ps
module triangle_face_normal_core
    import tfn_pkg::*;
#(
    parameter int COORD_WIDTH      = 16,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // fields from bit 0: v0_x v0_y v0_z v1_x v1_y v1_z v2_x v2_y v2_z, zero fill
    input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic                    s_tlast,    // last_in
    // fields from bit 0: normal_x normal_y normal_z
    output logic [47:0]             m_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic                    m_tlast,    // last_out
    output logic                    m_tuser     // degenerate
);
    localparam int CW    = COORD_WIDTH;
    localparam int DW    = CW + 1;          // difference width
    localparam int PW    = 2 * DW;          // product width
    localparam int XW    = PW + 1;          // cross component width
    localparam int F     = NORMAL_FRAC_BITS;
    localparam int NB    = F + 1;           // result bits per component
    localparam int SHW   = $clog2(XW + 1);

    // one stall for the whole pipe: every stage advances when the output may move
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // stage 1: differences
    logic signed [DW-1:0] a_reg [3], b_reg [3];
    logic                 v1_reg, l1_reg;
    // stage 2: products
    logic signed [PW-1:0] p_reg [6];
    logic                 v2_reg, l2_reg;
    // stage 3: cross product magnitudes and signs
    logic [XW-1:0]        c_reg [3];
    logic [2:0]           neg3_reg;
    logic                 v3_reg, l3_reg;
    // stage 4: max and shift amount
    logic [XW-1:0]        c4_reg [3];
    logic [SHW-1:0]       sh_reg;
    logic [2:0]           neg4_reg;
    logic                 v4_reg, l4_reg, z4_reg;
    // stage 5: squares of the shifted magnitudes
    logic [63:0]          sq5_reg [3];
    logic [2:0]           neg5_reg;
    logic                 v5_reg, l5_reg, z5_reg;
    // stage 6: sum of squares, squares kept for rhs m^2 << 2F+2
    logic [63:0]          sq6_reg [3];
    logic [63:0]          s6_reg;
    logic [2:0]           neg6_reg;
    logic                 v6_reg, l6_reg, z6_reg;

    // bit-serial rows, row 0 plus one per result bit; q = d^2*S and r = d*S for d = 2n-1
    logic [127:0]         rhs_reg [NB+1][3];
    logic signed [127:0]  q_reg   [NB+1][3];
    logic signed [127:0]  r_reg   [NB+1][3];
    logic [63:0]          sr_reg  [NB+1];
    logic [NB-1:0]        n_reg   [NB+1][3];
    logic [2:0]           negr_reg [NB+1];
    logic                 vr_reg [NB+1], lr_reg [NB+1], zr_reg [NB+1];

    logic signed [DW-1:0] vin [9];
    always_comb begin
        for (int i = 0; i < 9; i++)
            vin[i] = DW'($signed(s_tdata[i*CW +: CW]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0;
            v4_reg <= 1'b0; v5_reg <= 1'b0; v6_reg <= 1'b0;
            for (int k = 0; k <= NB; k++) vr_reg[k] <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid; v2_reg <= v1_reg; v3_reg <= v2_reg;
            v4_reg <= v3_reg; v5_reg <= v4_reg; v6_reg <= v5_reg;
            vr_reg[0] <= v6_reg;
            for (int k = 1; k <= NB; k++) vr_reg[k] <= vr_reg[k-1];
        end
    end

    // payload path
    logic signed [XW-1:0] cx [3];
    logic [XW-1:0]        mx;
    logic [SHW-1:0]       shn;
    logic [NB-1:0]        tn [NB][3];
    logic signed [127:0]  sx [NB];
    logic signed [127:0]  qc [NB][3];
    logic signed [127:0]  rc [NB][3];
    logic                 take [NB][3];
    always_comb begin
        cx[0] = XW'(p_reg[0]) - XW'(p_reg[1]);
        cx[1] = XW'(p_reg[2]) - XW'(p_reg[3]);
        cx[2] = XW'(p_reg[4]) - XW'(p_reg[5]);
        mx = c_reg[0];
        if (c_reg[1] > mx) mx = c_reg[1];
        if (c_reg[2] > mx) mx = c_reg[2];
        shn = '0;
        for (int b = 0; b < XW; b++)
            if (b >= MAG_WIDTH && mx[b]) shn = SHW'(b - MAG_WIDTH + 1);
        // d grows by 2^(b+1): d'^2 S = q + r*2^(b+2) + S*2^(2b+2), d' S = r + S*2^(b+1)
        for (int k = 0; k < NB; k++) begin
            sx[k] = $signed({64'd0, sr_reg[k]});
            for (int i = 0; i < 3; i++) begin
                tn[k][i]   = n_reg[k][i] | (NB'(1) << (F - k));
                qc[k][i]   = q_reg[k][i] + (r_reg[k][i] <<< (F - k + 2))
                           + (sx[k] <<< (2*(F - k) + 2));
                rc[k][i]   = r_reg[k][i] + (sx[k] <<< (F - k + 1));
                take[k][i] = ($unsigned(qc[k][i]) <= rhs_reg[k][i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                a_reg[i] <= vin[6+i] - vin[i];
                b_reg[i] <= vin[3+i] - vin[i];
            end
            l1_reg <= s_tlast;
            p_reg[0] <= a_reg[1] * b_reg[2]; p_reg[1] <= a_reg[2] * b_reg[1];
            p_reg[2] <= a_reg[2] * b_reg[0]; p_reg[3] <= a_reg[0] * b_reg[2];
            p_reg[4] <= a_reg[0] * b_reg[1]; p_reg[5] <= a_reg[1] * b_reg[0];
            l2_reg <= l1_reg;
            for (int i = 0; i < 3; i++) begin
                neg3_reg[i] <= cx[i][XW-1];
                c_reg[i] <= cx[i][XW-1] ? XW'(-cx[i]) : XW'(cx[i]);
            end
            l3_reg <= l2_reg;
            c4_reg <= c_reg; sh_reg <= shn; neg4_reg <= neg3_reg;
            z4_reg <= (mx == '0); l4_reg <= l3_reg;
            for (int i = 0; i < 3; i++) begin
                sq5_reg[i] <= 64'(MAG_WIDTH'(c4_reg[i] >> sh_reg))
                            * 64'(MAG_WIDTH'(c4_reg[i] >> sh_reg));
            end
            neg5_reg <= neg4_reg; z5_reg <= z4_reg; l5_reg <= l4_reg;
            sq6_reg <= sq5_reg; s6_reg <= sq5_reg[0] + sq5_reg[1] + sq5_reg[2];
            neg6_reg <= neg5_reg; z6_reg <= z5_reg; l6_reg <= l5_reg;
            // row 0 loads rhs = m^2 << 2F+2 and starts from n = 0, d = -1
            for (int i = 0; i < 3; i++) begin
                rhs_reg[0][i] <= 128'(sq6_reg[i]) << (2*F+2);
                q_reg[0][i]   <= $signed({64'd0, s6_reg});
                r_reg[0][i]   <= -$signed({64'd0, s6_reg});
                n_reg[0][i]   <= '0;
            end
            sr_reg[0] <= s6_reg; negr_reg[0] <= neg6_reg;
            zr_reg[0] <= z6_reg; lr_reg[0] <= l6_reg;
            // one result bit per row: keep t when d^2 * S <= rhs
            for (int k = 0; k < NB; k++) begin
                for (int i = 0; i < 3; i++) begin
                    rhs_reg[k+1][i] <= rhs_reg[k][i];
                    n_reg[k+1][i] <= take[k][i] ? tn[k][i] : n_reg[k][i];
                    q_reg[k+1][i] <= take[k][i] ? qc[k][i] : q_reg[k][i];
                    r_reg[k+1][i] <= take[k][i] ? rc[k][i] : r_reg[k][i];
                end
                sr_reg[k+1] <= sr_reg[k]; negr_reg[k+1] <= negr_reg[k];
                zr_reg[k+1] <= zr_reg[k]; lr_reg[k+1] <= lr_reg[k];
            end
        end
    end

    // output: zero normal for degenerate triangles, sign applied, masked to field
    logic [OUT_WIDTH-1:0] nout [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nout[i] = OUT_WIDTH'(n_reg[NB][i]);
            if (negr_reg[NB][i]) nout[i] = OUT_WIDTH'(-nout[i]);
            if (zr_reg[NB]) nout[i] = '0;
        end
    end
    assign m_tdata  = {nout[2], nout[1], nout[0]};
    assign m_tvalid = vr_reg[NB];
    assign m_tlast  = lr_reg[NB];
    assign m_tuser  = zr_reg[NB];
endmodule

// ===== verif/tb.sv =====
// tb: self-checking testbench for triangle_face_normal_core
// drives triangles on the s_ stream, predicts unit normals and checks the m_ stream
// depends on tfn_pkg and rtl/triangle_face_normal_core.sv
`timescale 1ns / 1ps

typedef struct {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               degen;
    logic               last;
} face_normal_t;

class normal_scoreboard;
    face_normal_t pending[$];
    int           errors = 0;

    // rounded unit magnitude: largest n with (2n-1)^2 * s <= m^2 * 2^(2F+2)
    function longint unsigned unit_mag(longint unsigned m, longint unsigned s);
        logic [127:0]    rhs;
        logic [127:0]    lhs;
        longint unsigned n;
        longint unsigned t;
        longint unsigned d;
        rhs = (128'(m) * 128'(m)) << 30;
        n = 0;
        for (int b = 14; b >= 0; b--) begin
            t = n | (64'd1 << b);
            d = 2 * t - 1;
            lhs = 128'(d * d) * 128'(s);
            if (lhs <= rhs) n = t;
        end
        return n;
    endfunction

    // predict the normal of one accepted triangle
    function void note_triangle(logic [143:0] d, logic last);
        longint          v[9];
        longint          c[3];
        longint unsigned m[3];
        longint unsigned big;
        longint unsigned s;
        longint unsigned n;
        face_normal_t    e;
        logic [15:0]     r[3];
        for (int i = 0; i < 9; i++) v[i] = longint'($signed(d[16*i +: 16]));
        // a = v2 - v0, b = v1 - v0, c = a x b
        c[0] = (v[7]-v[1])*(v[5]-v[2]) - (v[8]-v[2])*(v[4]-v[1]);
        c[1] = (v[8]-v[2])*(v[3]-v[0]) - (v[6]-v[0])*(v[5]-v[2]);
        c[2] = (v[6]-v[0])*(v[4]-v[1]) - (v[7]-v[1])*(v[3]-v[0]);
        e.last = last;
        e.degen = (c[0] == 0 && c[1] == 0 && c[2] == 0);
        big = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = c[i] < 0 ? longint'(-c[i]) : c[i];
            if (m[i] > big) big = m[i];
        end
        while (big >= 64'h8000_0000) begin
            big = big >> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        end
        s = m[0]*m[0] + m[1]*m[1] + m[2]*m[2];
        for (int i = 0; i < 3; i++) begin
            n = e.degen ? 0 : unit_mag(m[i], s);
            r[i] = c[i] < 0 ? 16'(-n) : 16'(n);
        end
        e.nx = r[0];
        e.ny = r[1];
        e.nz = r[2];
        pending.push_back(e);
    endfunction

    function void check_result(logic [47:0] d, logic last, logic degen);
        face_normal_t e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result %h last %b degen %b", $time, d, last, degen);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (d !== {e.nz, e.ny, e.nx} || last !== e.last || degen !== e.degen) begin
            $display("%0t: mismatch expected n=%0d,%0d,%0d degen %b last %b", $time,
                     e.nx, e.ny, e.nz, e.degen, e.last);
            $display("%0t:          actual   n=%0d,%0d,%0d degen %b last %b", $time,
                     $signed(d[15:0]), $signed(d[31:16]), $signed(d[47:32]), degen, last);
            errors++;
        end
    endfunction
endclass

module tb;
    import tfn_pkg::*;

    localparam int IN_BITS    = 144;
    localparam int WD_LIMIT   = 3000;
    localparam int HOLD_CYCLS = 400;

    logic               aclk;
    logic               aresetn;
    logic [IN_BITS-1:0] s_tdata;
    logic               s_tvalid;
    logic               s_tready;
    logic               s_tlast;
    logic [47:0]        m_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic               m_tlast;
    logic               m_tuser;

    normal_scoreboard sb;
    int  send_idle_pct;       // percent of cycles in which the sender idles
    int  recv_idle_pct;       // chance of the receiver stalling in a cycle
    int  hold_reqs = 0;       // count of long hold-offs asked of the receiver
    int  quiet_cycles = 0;

    triangle_face_normal_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // sample both channels at the edge; values seen here are pre-edge
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_triangle(s_tdata, s_tlast);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast, m_tuser);
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: random stalls, or one long hold-off on request
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_reqs != hold_seen && hold_left == 0) begin
                hold_left = HOLD_CYCLS;
                hold_seen = hold_reqs;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // offer one triangle, idling in a share of the cycles first
    task automatic send_triangle(logic [IN_BITS-1:0] d, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= d;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_vertices(int x0, int y0, int z0, int x1, int y1, int z1,
                                 int x2, int y2, int z2, logic last);
        send_triangle({16'(z2), 16'(y2), 16'(x2), 16'(z1), 16'(y1), 16'(x1),
                       16'(z0), 16'(y0), 16'(x0)}, last);
    endtask

    // random triangle: full range, small local, or degenerate
    task automatic send_random();
        int            kind;
        int            v[9];
        int            r;
        int            k;
        logic [IN_BITS-1:0] d;
        kind = $urandom_range(9);
        if (kind < 5) begin
            for (int i = 0; i < 9; i++) d[16*i +: 16] = 16'($urandom);
            send_triangle(d, $urandom_range(7) == 0);
        end else begin
            r = (kind < 8) ? (1 << $urandom_range(2, 12)) : 64;
            for (int i = 0; i < 3; i++) v[i] = $urandom_range(0, 60000) - 30000;
            for (int i = 3; i < 9; i++) v[i] = v[i-3] + $urandom_range(0, 2*r) - r;
            if (kind >= 8) begin
                k = $urandom_range(0, 3);
                // collinear: v2 = v0 + k*(v1 - v0), k = 0 repeats v0
                for (int i = 0; i < 3; i++) begin
                    v[3+i] = v[i] + $urandom_range(0, 2*r) - r;
                    v[6+i] = v[i] + k * (v[3+i] - v[i]);
                end
            end
            send_vertices(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8],
                          $urandom_range(7) == 0);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    initial begin
        sb = new();
        send_idle_pct = 22;
        recv_idle_pct = 79;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: degenerate, axis faces, extremes and both signs of every bit
        send_vertices(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        send_vertices(5, 5, 5, 5, 5, 5, 9, 1, 3, 1'b0);
        send_vertices(0, 0, 0, 256, 256, 256, 512, 512, 512, 1'b1);
        send_vertices(0, 0, 0, 256, 0, 0, 0, 256, 0, 1'b0);
        send_vertices(0, 0, 0, 0, 256, 0, 256, 0, 0, 1'b0);
        send_vertices(0, 0, 0, 0, 0, 256, 0, 256, 0, 1'b0);
        send_vertices(0, 0, 0, 256, 0, 0, 0, 0, 256, 1'b0);
        send_vertices(0, 0, 0, 1, 0, 0, 0, 1, 0, 1'b0);
        send_vertices(-32768, -32768, -32768, 32767, -32768, -32768,
                      -32768, 32767, -32768, 1'b0);
        send_vertices(32767, 32767, 32767, -32768, 32767, 32767,
                      32767, -32768, 32767, 1'b0);
        send_vertices(-32768, 32767, -32768, 32767, -32768, 32767,
                      32767, 32767, -32768, 1'b1);
        send_vertices(-32768, -32768, -32768, 32767, 32767, -32768,
                      -32768, 32767, 32767, 1'b0);
        send_vertices(0, 0, 0, 1, 0, 0, 0, 1, 1, 1'b0);
        send_vertices(100, 200, 300, 101, 200, 300, 100, 200, 301, 1'b0);
        send_vertices(0, 0, 0, 3, 1, 0, 1, 3, 0, 1'b0);
        send_vertices(-1, -1, -1, -1, -1, -1, -1, -1, -1, 1'b1);
        send_triangle({IN_BITS{1'b1}}, 1'b1);
        send_triangle({9{16'h5555}} ^ {8'h00, {17{8'hf0}}}, 1'b0);

        // pause until every outstanding normal has come back
        wait_drained();

        // long receiver hold-off while triangles keep coming
        hold_reqs++;
        for (int i = 0; i < 40; i++) send_random();

        for (int i = 0; i < 250; i++) send_random();
        wait_drained();
        send_idle_pct = 79;
        recv_idle_pct = 22;
        for (int i = 0; i < 250; i++) send_random();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 220; i++) send_random();

        wait_drained();
        repeat (30) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
